[hdl/slwb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slwb_pkg: shared types and constants for the sector LRU write buffer
// Request/response payloads, controller state codes, popcount helper.
// ----------------------------------------------------------------------------
package slwb_pkg;

	localparam int SECTORS_PER_PAGE_DEF = 4;
	localparam int ENTRIES_DEF = 1024;
	localparam logic [15:0] CAP_RESET = 16'd4096;
	localparam logic [5:0] MAX_EVICT = 6'd32;

	localparam logic ACT_READ  = 1'b0;
	localparam logic ACT_WRITE = 1'b1;
	localparam logic KIND_WB   = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef struct packed {
		logic        action;
		logic [31:0] page_number;
		logic [31:0] sector_mask;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] out_page;
		logic [31:0] out_mask;
		logic [5:0]  out_sectors;
		logic [5:0]  hit_sectors;
		logic        last;
	} rsp_t;

	// per-field write enables of the entry memory
	typedef struct packed {
		logic valid;
		logic page;
		logic stored;
		logic prev;
		logic next;
	} ent_we_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_DISPATCH,
		ST_TH_RD,
		ST_TH_CAP,
		ST_U1,
		ST_U2,
		ST_H1,
		ST_H2,
		ST_EV_RD,
		ST_EV_CAP,
		ST_EV_LOAD,
		ST_EV_INV,
		ST_WM_LOOP,
		ST_WM_INS,
		ST_WH_BIT,
		ST_WH_NEXT,
		ST_WH_PRD,
		ST_WH_PCAP,
		ST_WH_PRD2,
		ST_WH_PCAP2,
		ST_PT1,
		ST_PT2,
		ST_WH_ADD,
		ST_WH_SET,
		ST_DONE
	} state_t;

	function automatic logic [5:0] popcount(input logic [31:0] v);
		logic [5:0] c;
		c = 6'd0;
		for (int i = 0; i < 32; i++) begin
			c = c + {5'd0, v[i]};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[hdl/sector_lru_write_buffer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sector_lru_write_buffer
// Page-tagged write buffer tracking stored sectors per page, kept in LRU
// order on a doubly linked list held in one entry memory.
// ----------------------------------------------------------------------------
// Usage:
//  in_valid/in_ready take one request (read or write of a page with a sector
//  mask). out_valid/out_ready deliver responses: one write-back per evicted
//  page, then one completion with last set. cfg_valid/cfg_ready write
//  capacity_sectors; cfg_ready is always high.
//  Every request first scans the whole entry memory, one entry per cycle, to
//  find the page and the lowest free slot. List updates follow; an eviction
//  reads the tail entry, loads its write-back and invalidates it before its
//  unlink, and a write hit walks its mask one sector per step.
//  After reset a clearing pass marks every entry invalid; no request is
//  taken meanwhile. A stalled receiver holds the output register; the
//  controller waits before loading the next response, and a new request may
//  be taken while the completion still waits.
// ----------------------------------------------------------------------------
module sector_lru_write_buffer #(
	parameter int SECTORS_PER_PAGE = slwb_pkg::SECTORS_PER_PAGE_DEF,
	parameter int ENTRIES = slwb_pkg::ENTRIES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire slwb_pkg::req_t in_req,
	output logic                out_valid,
	input  wire logic           out_ready,
	output slwb_pkg::rsp_t      out_rsp,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [15:0]    cfg_data
);
	import slwb_pkg::*;

	localparam int S = SECTORS_PER_PAGE;
	localparam int AW = $clog2(ENTRIES);
	localparam int IW = AW + 1;
	localparam int UW = $clog2(ENTRIES * S + 1);
	localparam int CW = ((UW > 16) ? UW : 16) + 1;
	localparam logic [IW-1:0] NONE = IW'(ENTRIES);

	typedef struct packed {
		logic          valid;
		logic [31:0]   page;
		logic [S-1:0]  stored;
		logic [IW-1:0] prev;
		logic [IW-1:0] next;
	} entry_t;

	// entry memory and its ports
	entry_t  mem [ENTRIES];
	entry_t  rd_q;
	logic    mem_ren;
	logic [AW-1:0] mem_ra, mem_wa;
	ent_we_t mem_we;
	entry_t  mem_wd;

	state_t state_q, state_d;
	state_t th_ret_q, u_ret_q, h_ret_q, ev_ret_q;

	logic [AW-1:0] clr_q, scan_q, sidx_s1;
	logic          sv_s1;
	logic          act_q;
	logic [31:0]   page_q;
	logic [S-1:0]  m_q, es_q, missed_q, bit_q, evs_q;
	logic [5:0]    cnt_q, hits_q, ev_cnt_q;
	logic          found_q, free_found_q;
	logic [IW-1:0] e_q, free_idx_q, px_q, nx_q, x_q, pr_q, t_q;
	logic [IW-1:0] head_q, tail_q;
	logic [UW-1:0] used_q;
	logic [15:0]   cap_q;
	logic [31:0]   evp_q;
	logic          out_valid_q;
	rsp_t          out_q;

	logic need_evict, evict_cond;
	logic [CW-1:0] used_x, cap_x, cnt_x, evc_x;

	assign used_x = CW'(used_q);
	assign cap_x  = CW'(cap_q);
	assign cnt_x  = CW'(cnt_q);
	assign evc_x  = CW'(popcount(32'(evs_q)));

	assign need_evict = (used_x >= cap_x) && !((head_q == e_q) && (tail_q == e_q));
	assign evict_cond = (head_q != NONE) && (ev_cnt_q < MAX_EVICT) &&
		((used_x + cnt_x > cap_x) || !free_found_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_rsp   = out_q;

	// entry memory: field write enables, registered read
	always_ff @(posedge clk) begin
		if (mem_we.valid)  mem[mem_wa].valid  <= mem_wd.valid;
		if (mem_we.page)   mem[mem_wa].page   <= mem_wd.page;
		if (mem_we.stored) mem[mem_wa].stored <= mem_wd.stored;
		if (mem_we.prev)   mem[mem_wa].prev   <= mem_wd.prev;
		if (mem_we.next)   mem[mem_wa].next   <= mem_wd.next;
		if (mem_ren)       rd_q <= mem[mem_ra];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:     if (clr_q == AW'(ENTRIES - 1)) state_d = ST_IDLE;
			ST_IDLE:      if (in_valid) state_d = ST_SCAN;
			ST_SCAN:      if (scan_q == AW'(ENTRIES - 1)) state_d = ST_SCAN_LAST;
			ST_SCAN_LAST: state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				if (act_q == ACT_READ) begin
					state_d = (found_q && ((es_q & m_q) != '0)) ? ST_TH_RD : ST_DONE;
				end else if (m_q == '0) begin
					state_d = ST_DONE;
				end else begin
					state_d = found_q ? ST_WH_BIT : ST_WM_LOOP;
				end
			end
			ST_TH_RD:     state_d = ST_TH_CAP;
			ST_TH_CAP:    state_d = (head_q == e_q) ? th_ret_q : ST_U1;
			ST_U1:        state_d = ST_U2;
			ST_U2:        state_d = u_ret_q;
			ST_H1:        state_d = ST_H2;
			ST_H2:        state_d = h_ret_q;
			ST_EV_RD:     state_d = ST_EV_CAP;
			ST_EV_CAP:    state_d = ST_EV_LOAD;
			ST_EV_LOAD:   if (!out_valid_q) state_d = ST_EV_INV;
			ST_EV_INV:    state_d = ST_U1;
			ST_WM_LOOP: begin
				if (evict_cond) state_d = ST_EV_RD;
				else state_d = free_found_q ? ST_WM_INS : ST_DONE;
			end
			ST_WM_INS:    state_d = ST_H1;
			ST_WH_BIT: begin
				if (bit_q == '0) state_d = ST_DONE;
				else if ((m_q & bit_q) == '0) state_d = ST_WH_BIT;
				else if ((es_q & bit_q) != '0) state_d = ST_TH_RD;
				else if (need_evict) state_d = (tail_q == e_q) ? ST_WH_PRD : ST_EV_RD;
				else state_d = ST_WH_ADD;
			end
			ST_WH_NEXT:   state_d = ST_WH_BIT;
			ST_WH_PRD:    state_d = ST_WH_PCAP;
			ST_WH_PCAP:   state_d = (rd_q.prev != NONE) ? ST_WH_PRD2 : ST_EV_RD;
			ST_WH_PRD2:   state_d = ST_WH_PCAP2;
			ST_WH_PCAP2:  state_d = ST_U1;
			ST_PT1:       state_d = ST_PT2;
			ST_PT2:       state_d = ST_EV_RD;
			ST_WH_ADD:    state_d = ST_TH_RD;
			ST_WH_SET:    state_d = ST_WH_BIT;
			ST_DONE:      if (!out_valid_q) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// memory control per state
	always_comb begin
		mem_ren = 1'b0;
		mem_ra  = '0;
		mem_wa  = '0;
		mem_we  = '0;
		mem_wd  = '0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_wa = clr_q;
				mem_we.valid = 1'b1;
			end
			ST_SCAN: begin
				mem_ren = 1'b1;
				mem_ra = scan_q;
			end
			ST_TH_RD, ST_WH_PRD: begin
				mem_ren = 1'b1;
				mem_ra = e_q[AW-1:0];
			end
			ST_EV_RD: begin
				mem_ren = 1'b1;
				mem_ra = tail_q[AW-1:0];
			end
			ST_WH_PRD2: begin
				mem_ren = 1'b1;
				mem_ra = pr_q[AW-1:0];
			end
			ST_U1: begin
				mem_wa = px_q[AW-1:0];
				mem_we.next = (px_q != NONE);
				mem_wd.next = nx_q;
			end
			ST_U2: begin
				mem_wa = nx_q[AW-1:0];
				mem_we.prev = (nx_q != NONE);
				mem_wd.prev = px_q;
			end
			ST_H1: begin
				mem_wa = x_q[AW-1:0];
				mem_we.prev = 1'b1;
				mem_we.next = 1'b1;
				mem_wd.prev = NONE;
				mem_wd.next = head_q;
			end
			ST_H2: begin
				mem_wa = head_q[AW-1:0];
				mem_we.prev = (head_q != NONE);
				mem_wd.prev = x_q;
			end
			ST_PT1: begin
				mem_wa = pr_q[AW-1:0];
				mem_we.prev = 1'b1;
				mem_we.next = 1'b1;
				mem_wd.prev = tail_q;
				mem_wd.next = NONE;
			end
			ST_PT2: begin
				mem_wa = tail_q[AW-1:0];
				mem_we.next = (tail_q != NONE);
				mem_wd.next = pr_q;
			end
			ST_EV_INV: begin
				mem_wa = t_q[AW-1:0];
				mem_we.valid = 1'b1;
			end
			ST_WM_INS: begin
				mem_wa = free_idx_q[AW-1:0];
				mem_we.valid = 1'b1;
				mem_we.page = 1'b1;
				mem_we.stored = 1'b1;
				mem_wd.valid = 1'b1;
				mem_wd.page = page_q;
				mem_wd.stored = m_q;
			end
			ST_WH_SET: begin
				mem_wa = e_q[AW-1:0];
				mem_we.stored = 1'b1;
				mem_wd.stored = es_q | bit_q;
			end
			default: ;
		endcase
	end

	// control and list registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			head_q      <= NONE;
			tail_q      <= NONE;
			used_q      <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
			sv_s1       <= 1'b0;
			found_q     <= 1'b0;
			free_found_q <= 1'b0;
			th_ret_q    <= ST_DONE;
			u_ret_q     <= ST_DONE;
			h_ret_q     <= ST_DONE;
			ev_ret_q    <= ST_DONE;
		end else begin
			state_q <= state_d;
			if (cfg_valid) cap_q <= cfg_data;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			sv_s1 <= (state_q == ST_SCAN);

			// scan compare, one entry per cycle
			if (sv_s1) begin
				if (rd_q.valid && (rd_q.page == page_q) && !found_q) begin
					found_q <= 1'b1;
					e_q     <= {1'b0, sidx_s1};
					es_q    <= rd_q.stored;
				end
				if (!rd_q.valid && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= {1'b0, sidx_s1};
				end
			end

			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: if (in_valid) begin
					act_q    <= in_req.action;
					page_q   <= in_req.page_number;
					m_q      <= in_req.sector_mask[S-1:0];
					cnt_q    <= popcount(32'(in_req.sector_mask[S-1:0]));
					found_q  <= 1'b0;
					free_found_q <= 1'b0;
					hits_q   <= '0;
					missed_q <= '0;
					ev_cnt_q <= '0;
					bit_q    <= S'(1);
					scan_q   <= '0;
				end
				ST_SCAN: scan_q <= scan_q + 1'b1;
				ST_DISPATCH: if (act_q == ACT_READ) begin
					th_ret_q <= ST_DONE;
					if (found_q) begin
						hits_q   <= popcount(32'(es_q & m_q));
						missed_q <= m_q & ~es_q;
					end else begin
						missed_q <= m_q;
					end
				end
				ST_TH_CAP: begin
					px_q    <= rd_q.prev;
					nx_q    <= rd_q.next;
					x_q     <= e_q;
					h_ret_q <= th_ret_q;
					u_ret_q <= ST_H1;
				end
				ST_U1: if (px_q == NONE) head_q <= nx_q;
				ST_U2: if (nx_q == NONE) tail_q <= px_q;
				ST_H2: begin
					if (head_q == NONE) tail_q <= x_q;
					head_q <= x_q;
				end
				ST_EV_RD: t_q <= tail_q;
				ST_EV_CAP: begin
					evp_q <= rd_q.page;
					evs_q <= rd_q.stored;
					px_q  <= rd_q.prev;
					nx_q  <= rd_q.next;
				end
				ST_EV_LOAD: if (!out_valid_q) begin
					out_valid_q       <= 1'b1;
					out_q.kind        <= KIND_WB;
					out_q.out_page    <= evp_q;
					out_q.out_mask    <= 32'(evs_q);
					out_q.out_sectors <= popcount(32'(evs_q));
					out_q.hit_sectors <= '0;
					out_q.last        <= 1'b0;
				end
				ST_EV_INV: begin
					used_q  <= (used_x >= evc_x) ? UW'(used_x - evc_x) : '0;
					u_ret_q <= ev_ret_q;
					if (!free_found_q || (t_q < free_idx_q)) free_idx_q <= t_q;
					free_found_q <= 1'b1;
				end
				ST_WM_LOOP: if (evict_cond) begin
					ev_cnt_q <= ev_cnt_q + 1'b1;
					ev_ret_q <= ST_WM_LOOP;
				end
				ST_WM_INS: begin
					used_q  <= UW'(used_x + cnt_x);
					x_q     <= free_idx_q;
					h_ret_q <= ST_DONE;
				end
				ST_WH_BIT: if (bit_q != '0) begin
					if ((m_q & bit_q) == '0) begin
						bit_q <= S'(bit_q << 1);
					end else if ((es_q & bit_q) != '0) begin
						hits_q   <= hits_q + 1'b1;
						th_ret_q <= ST_WH_NEXT;
					end else if (need_evict) begin
						ev_ret_q <= ST_WH_ADD;
					end
				end
				ST_WH_NEXT: bit_q <= S'(bit_q << 1);
				ST_WH_PCAP: pr_q <= rd_q.prev;
				ST_WH_PCAP2: begin
					px_q    <= rd_q.prev;
					nx_q    <= rd_q.next;
					u_ret_q <= ST_PT1;
				end
				ST_PT2: begin
					if (tail_q == NONE) head_q <= pr_q;
					tail_q <= pr_q;
				end
				ST_WH_ADD: th_ret_q <= ST_WH_SET;
				ST_WH_SET: begin
					es_q   <= es_q | bit_q;
					used_q <= used_q + 1'b1;
					bit_q  <= S'(bit_q << 1);
				end
				ST_DONE: if (!out_valid_q) begin
					out_valid_q       <= 1'b1;
					out_q.kind        <= KIND_DONE;
					out_q.out_page    <= page_q;
					out_q.out_mask    <= 32'(missed_q);
					out_q.out_sectors <= popcount(32'(missed_q));
					out_q.hit_sectors <= hits_q;
					out_q.last        <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// scan index pipeline
	always_ff @(posedge clk) begin
		sidx_s1 <= scan_q;
	end

	// checks
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while a previous one is in flight");

	a_wb_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_rsp.kind == KIND_WB)) |->
		(!out_rsp.last && (out_rsp.hit_sectors == 6'd0)))
		else $error("write-back response carries completion fields");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_rsp.kind == KIND_DONE)) |-> out_rsp.last)
		else $error("completion without last");

	a_ev_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EV_LOAD && !out_valid) |=> (out_valid && (out_rsp.kind == KIND_WB)))
		else $error("eviction response not loaded");

endmodule
`default_nettype wire

[tb/sector_lru_write_buffer_tb.sv]
// ----------------------------------------------------------------------------
// sector_lru_write_buffer_tb: self-checking bench for the sector LRU buffer
// Drives reads and writes over a small page pool under several capacities.
// A scoreboard keeps its own page list and checks every response in order.
// ----------------------------------------------------------------------------
class slwb_scoreboard;
	localparam int NSLOT = slwb_pkg::ENTRIES_DEF;
	localparam int NONE = slwb_pkg::ENTRIES_DEF;
	localparam int NSEC = slwb_pkg::SECTORS_PER_PAGE_DEF;

	bit [31:0] pg [NSLOT];
	bit [31:0] held [NSLOT];
	bit        used [NSLOT];
	int        prv [NSLOT];
	int        nxt [NSLOT];
	int        head, tail;
	int        fill;
	int        cap;
	slwb_pkg::rsp_t pending_rsp [$];
	int        errors;
	int        seen;

	function new();
		for (int i = 0; i < NSLOT; i++) begin
			used[i] = 0;
		end
		head = NONE;
		tail = NONE;
		fill = 0;
		cap = 4096;
		errors = 0;
		seen = 0;
	endfunction

	function int ones(bit [31:0] v);
		int c;
		c = 0;
		for (int i = 0; i < 32; i++) c += v[i];
		return c;
	endfunction

	function void push_rsp(bit k, bit [31:0] p, bit [31:0] m, int h, bit l);
		slwb_pkg::rsp_t r;
		r.kind = k;
		r.out_page = p;
		r.out_mask = m;
		r.out_sectors = 6'(ones(m));
		r.hit_sectors = 6'(h);
		r.last = l;
		pending_rsp.push_back(r);
	endfunction

	function void unlink(int e);
		int p, n;
		p = prv[e];
		n = nxt[e];
		if (p == NONE) head = n; else nxt[p] = n;
		if (n == NONE) tail = p; else prv[n] = p;
	endfunction

	function void link_head(int e);
		prv[e] = NONE;
		nxt[e] = head;
		if (head != NONE) prv[head] = e; else tail = e;
		head = e;
	endfunction

	function void link_tail(int e);
		nxt[e] = NONE;
		prv[e] = tail;
		if (tail != NONE) nxt[tail] = e; else head = e;
		tail = e;
	endfunction

	function void promote(int e);
		if (head != e) begin
			unlink(e);
			link_head(e);
		end
	endfunction

	function void drop_tail();
		int t, c;
		t = tail;
		if (t == NONE) return;
		c = ones(held[t]);
		push_rsp(slwb_pkg::KIND_WB, pg[t], held[t], 0, 1'b0);
		fill = (fill >= c) ? fill - c : 0;
		unlink(t);
		used[t] = 0;
	endfunction

	function int lookup(bit [31:0] p);
		for (int i = 0; i < NSLOT; i++) if (used[i] && pg[i] == p) return i;
		return NONE;
	endfunction

	function int free_slot();
		for (int i = 0; i < NSLOT; i++) if (!used[i]) return i;
		return NONE;
	endfunction

	// predict the responses of one accepted request
	function void note(slwb_pkg::req_t q);
		bit [31:0] m, bitv, missed;
		int e, hits, cnt, ev, slot, p;
		m = q.sector_mask & ((32'd1 << NSEC) - 32'd1);
		hits = 0;
		missed = 0;
		e = lookup(q.page_number);
		if (q.action == slwb_pkg::ACT_READ) begin
			if (e != NONE) begin
				if ((held[e] & m) != 0) promote(e);
				hits = ones(held[e] & m);
				missed = m & ~held[e];
			end else begin
				missed = m;
			end
		end else if (m != 0) begin
			if (e == NONE) begin
				cnt = ones(m);
				ev = 0;
				while (head != NONE && ev < 32 &&
				       (fill + cnt > cap || free_slot() == NONE)) begin
					drop_tail();
					ev++;
				end
				slot = free_slot();
				if (slot != NONE) begin
					used[slot] = 1;
					pg[slot] = q.page_number;
					held[slot] = m;
					link_head(slot);
					fill += cnt;
				end
			end else begin
				for (int i = 0; i < NSEC; i++) begin
					bitv = 32'd1 << i;
					if ((m & bitv) == 0) continue;
					if ((held[e] & bitv) != 0) begin
						promote(e);
						hits++;
						continue;
					end
					if (fill >= cap && !(head == e && tail == e)) begin
						// hit page at the tail swaps with its predecessor first
						if (tail == e) begin
							p = prv[e];
							if (p != NONE) begin
								unlink(p);
								link_tail(p);
							end
						end
						drop_tail();
					end
					promote(e);
					held[e] |= bitv;
					fill++;
				end
			end
		end
		push_rsp(slwb_pkg::KIND_DONE, q.page_number, missed, hits, 1'b1);
	endfunction

	function void check(slwb_pkg::rsp_t a);
		slwb_pkg::rsp_t x;
		seen++;
		if (pending_rsp.size() == 0) begin
			$error("unexpected response page %h", a.out_page);
			errors++;
			return;
		end
		x = pending_rsp.pop_front();
		if (a.kind !== x.kind) begin
			$error("kind: expected %0d, got %0d", x.kind, a.kind);
			errors++;
		end
		if (a.out_page !== x.out_page) begin
			$error("out_page: expected %h, got %h", x.out_page, a.out_page);
			errors++;
		end
		if (a.out_mask !== x.out_mask) begin
			$error("out_mask: expected %h, got %h", x.out_mask, a.out_mask);
			errors++;
		end
		if (a.out_sectors !== x.out_sectors) begin
			$error("out_sectors: expected %0d, got %0d", x.out_sectors, a.out_sectors);
			errors++;
		end
		if (a.hit_sectors !== x.hit_sectors) begin
			$error("hit_sectors: expected %0d, got %0d", x.hit_sectors, a.hit_sectors);
			errors++;
		end
		if (a.last !== x.last) begin
			$error("last: expected %0d, got %0d", x.last, a.last);
			errors++;
		end
	endfunction
endclass

module sector_lru_write_buffer_tb;
	import slwb_pkg::*;

	localparam longint CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	req_t        in_req;
	logic        out_valid;
	logic        out_ready;
	rsp_t        out_rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;

	slwb_scoreboard sb;
	longint cycles;
	int     idle_pct;
	int     stall_pct;
	int     n_req;
	bit [31:0] pool [8];

	sector_lru_write_buffer uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_req(in_req),
		.out_valid(out_valid), .out_ready(out_ready), .out_rsp(out_rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check(out_rsp);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("sector_lru_write_buffer_tb: done, errors");
			$finish;
		end
	end

	task automatic send_req(logic act, logic [31:0] page, logic [31:0] mask);
		req_t r;
		r.action = act;
		r.page_number = page;
		r.sector_mask = mask;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_req <= r;
		do @(posedge clk); while (!in_ready);
		sb.note(r);
		n_req++;
	endtask

	// wait until every predicted response has been seen
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_rsp.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_capacity(logic [15:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.cap = int'(v);
	endtask

	task automatic random_req();
		logic [31:0] page;
		page = ($urandom_range(99) < 85) ? pool[$urandom_range(7)] : $urandom;
		send_req(($urandom_range(99) < 70) ? ACT_WRITE : ACT_READ, page, $urandom);
	endtask

	initial begin
		logic [15:0] caps [6];
		sb = new();
		cycles = 0;
		n_req = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_req = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = CAP_RESET;
		pool = '{32'h0, 32'hffffffff, 32'h1, 32'h80000000, 32'h5a5a5a5a,
		         32'h7, 32'h12345678, 32'hfffffffe};
		caps = '{16'd4, 16'd1, 16'd32768, 16'd12, 16'd2, 16'd4096};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: read miss, empty write, hits, evictions at a one-sector capacity
		send_req(ACT_READ, 32'h0, 32'hffffffff);
		send_req(ACT_WRITE, 32'h0, 32'h0);
		send_req(ACT_WRITE, 32'h0, 32'h0000000f);
		send_req(ACT_READ, 32'h0, 32'h00000003);
		send_req(ACT_WRITE, 32'hffffffff, 32'hfffffff5);
		send_req(ACT_WRITE, 32'hffffffff, 32'h0000000a);
		send_req(ACT_READ, 32'hffffffff, 32'h0000000f);
		send_req(ACT_READ, 32'h1, 32'hfffffff0);
		set_capacity(16'd1);
		send_req(ACT_WRITE, 32'h2, 32'h00000003);
		send_req(ACT_WRITE, 32'h2, 32'h0000000c);
		send_req(ACT_WRITE, 32'h3, 32'h00000001);
		send_req(ACT_WRITE, 32'h4, 32'h00000001);
		send_req(ACT_WRITE, 32'h3, 32'h00000002);
		send_req(ACT_READ, 32'h4, 32'h00000001);
		set_capacity(16'd32768);
		send_req(ACT_WRITE, 32'h80000000, 32'h00000009);
		send_req(ACT_READ, 32'h80000000, 32'h0000000f);

		// eviction cap: fill with single-sector pages, then shrink capacity
		set_capacity(16'd200);
		for (int i = 0; i < 40; i++) send_req(ACT_WRITE, 32'h1000 + i, 32'h1);
		set_capacity(16'd1);
		send_req(ACT_WRITE, 32'h2000, 32'hf);
		send_req(ACT_WRITE, 32'h2001, 32'h3);

		// random phases over capacities and idle patterns
		for (int ph = 0; ph < 12; ph++) begin
			set_capacity(caps[ph % 6]);
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 49; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 49; end
				default: begin idle_pct = 11; stall_pct = 11; end
			endcase
			for (int k = 0; k < 18; k++) begin
				random_req();
				// let the buffer run dry once mid-phase
				if (ph == 5 && k == 9) drain();
			end
		end

		drain();
		$display("covered %0d requests and %0d responses over 7 capacity values",
		         n_req, sb.seen);
		if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
			$display("sector_lru_write_buffer_tb: done, clean");
		end else begin
			$display("sector_lru_write_buffer_tb: done, errors");
		end
		$finish;
	end
endmodule
